// File: design/ffpa_pkg.sv
// ============================================================================
// First-fit pool allocator package
// Shared field widths, pool size, action codes and the command and status
// bundles that pass between the controller and the datapath.
// ============================================================================
package ffpa_pkg;

   // Pool size in bytes; the offset fields below are sized for it.
   localparam int POOL_SIZE = 2048;

   // Field widths of the input and result items.
   localparam int ACTION_W    = 2;
   localparam int REQ_W       = 16;
   localparam int OFF_W       = 11;
   localparam int COPY_W      = 11;
   localparam int REQ_TDATA_W = 32;
   localparam int RSP_TDATA_W = 24;

   // Action codes carried in the input beat.
   typedef enum logic [ACTION_W-1:0] {
      ACT_ALLOC   = 2'd0,
      ACT_RELEASE = 2'd1,
      ACT_RESIZE  = 2'd2,
      ACT_NONE    = 2'd3
   } action_type;

   // Datapath operations issued by the controller, one per cycle.
   typedef enum logic [3:0] {
      OP_IDLE       = 4'd0,
      OP_INIT       = 4'd1,
      OP_LOAD       = 4'd2,
      OP_WALK_START = 4'd3,
      OP_WALK       = 4'd4,
      OP_SPLIT      = 4'd5,
      OP_RD_HDR     = 4'd6,
      OP_RSZ_CHK    = 4'd7,
      OP_REL_MARK   = 4'd8,
      OP_REL_MERGE  = 4'd9
   } dp_op_type;

   // Controller to datapath.
   typedef struct packed {
      dp_op_type op;
      logic      set_moved;
      logic      publish;
   } ffpa_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      action_type act;
      logic       ptr_zero;
      logic       ptr_ok;
      logic       req_zero;
      logic       fit;
      logic       split;
      logic       walk_end;
      logic       in_place;
      logic       mark_end;
      logic       merge_end;
   } ffpa_status_type;

endpackage

// File: design/ffpa_datapath.sv
// ============================================================================
// First-fit pool allocator datapath
// Header memory, walk and release arithmetic, item and result registers.
// ============================================================================
module ffpa_datapath
   import ffpa_pkg::*;
#(
   parameter int HEADER_BYTES = 12
) (
   input  logic                clock,
   input  logic [ACTION_W-1:0] action,
   input  logic [REQ_W-1:0]    request_bytes,
   input  logic [OFF_W-1:0]    block_offset,
   input  ffpa_cmd_type        cmd,
   output ffpa_status_type     status,
   output logic [OFF_W-1:0]    result_offset,
   output logic                success,
   output logic                moved,
   output logic [COPY_W-1:0]   copy_bytes
);

   localparam int LW    = $clog2(POOL_SIZE + 1);
   localparam int CW    = (LW + 2 > REQ_W + 2) ? LW + 2 : REQ_W + 2;
   localparam int SLOTS = (POOL_SIZE + 3) / 4;
   localparam int SW    = $clog2(SLOTS);

   localparam logic [CW-1:0] POOL_C  = CW'(POOL_SIZE);
   localparam logic [CW-1:0] HDR_C   = CW'(HEADER_BYTES);
   localparam logic [CW-1:0] ROUND_C = CW'(7);
   localparam logic [CW-1:0] MIN_C   = CW'(8);
   localparam logic [LW-1:0] INIT_LEN = LW'(POOL_SIZE - HEADER_BYTES);

   // Header memory: one word per 4 pool bytes, free mark above the length.
   logic [LW:0] mem_ff [SLOTS];
   logic [LW:0] rd_word_ff;
   logic        rd_oob_ff;

   logic          rd_en;
   logic [CW-1:0] rd_off;
   logic          wr_en;
   logic [CW-1:0] wr_off;
   logic [LW:0]   wr_word;

   // Item registers.
   action_type        act_ff, act_in;
   logic [REQ_W-1:0]  req_ff, req_in;
   logic [OFF_W-1:0]  ptr_ff, ptr_in;
   logic [CW-1:0]     cur_ff, cur_in;
   logic [LW-1:0]     len_ff, len_in;
   logic [LW-1:0]     old_len_ff, old_len_in;

   // Result being built and the result on offer.
   logic [OFF_W-1:0]  res_ff, res_in;
   logic              moved_ff, moved_in;
   logic [COPY_W-1:0] copy_ff, copy_in;
   logic [OFF_W-1:0]  out_res_ff, out_res_in;
   logic              out_moved_ff, out_moved_in;
   logic [COPY_W-1:0] out_copy_ff, out_copy_in;

   // Arithmetic on the current header word.
   logic [LW-1:0] rd_len;
   logic          rd_free;
   logic [CW-1:0] rd_len_w;
   logic [CW-1:0] need;
   logic [CW-1:0] hdr_off;
   logic [CW-1:0] walk_next;
   logic [CW-1:0] split_off;
   logic [CW-1:0] remain;
   logic [CW-1:0] mark_next;
   logic [CW-1:0] merge_raw;
   logic [CW-1:0] merged;
   logic [CW-1:0] merge_next;
   logic [CW-1:0] ptr_w;
   logic [CW-1:0] cur_usable;
   logic [CW-1:0] old_len_w;

   assign rd_len     = rd_oob_ff ? '0 : rd_word_ff[LW-1:0];
   assign rd_free    = !rd_oob_ff && rd_word_ff[LW];
   assign rd_len_w   = CW'(rd_len);
   assign need       = (CW'(req_ff) + ROUND_C) & ~ROUND_C;
   assign ptr_w      = CW'(ptr_ff);
   assign hdr_off    = ptr_w - HDR_C;
   assign walk_next  = cur_ff + HDR_C + rd_len_w;
   assign split_off  = cur_ff + HDR_C + need;
   assign remain     = rd_len_w - need - HDR_C;
   assign mark_next  = hdr_off + HDR_C + rd_len_w;
   assign merge_raw  = CW'(len_ff) + HDR_C + rd_len_w;
   assign merged     = (merge_raw > POOL_C) ? POOL_C : merge_raw;
   assign merge_next = hdr_off + HDR_C + merged;
   assign cur_usable = cur_ff + HDR_C;
   assign old_len_w  = CW'(old_len_ff);

   // Status toward the controller.
   always_comb begin
      status.act       = act_ff;
      status.ptr_zero  = (ptr_ff == '0);
      status.ptr_ok    = (ptr_w >= HDR_C) && (ptr_w < POOL_C);
      status.req_zero  = (req_ff == '0);
      status.fit       = rd_free && (rd_len_w >= need);
      status.split     = (rd_len_w >= need + HDR_C + MIN_C);
      status.walk_end  = (walk_next >= POOL_C);
      status.in_place  = (rd_len_w >= CW'(req_ff));
      status.mark_end  = (mark_next >= POOL_C);
      status.merge_end = !rd_free || (merged == CW'(len_ff)) || (merge_next >= POOL_C);
   end

   // Operation decode: memory port controls and register next values.
   always_comb begin
      rd_en        = 1'b0;
      rd_off       = '0;
      wr_en        = 1'b0;
      wr_off       = '0;
      wr_word      = '0;
      act_in       = act_ff;
      req_in       = req_ff;
      ptr_in       = ptr_ff;
      cur_in       = cur_ff;
      len_in       = len_ff;
      old_len_in   = old_len_ff;
      res_in       = res_ff;
      moved_in     = moved_ff;
      copy_in      = copy_ff;
      out_res_in   = out_res_ff;
      out_moved_in = out_moved_ff;
      out_copy_in  = out_copy_ff;

      case (cmd.op)
         OP_INIT: begin
            wr_en   = 1'b1;
            wr_off  = '0;
            wr_word = {1'b1, INIT_LEN};
         end
         OP_LOAD: begin
            act_in   = action_type'(action);
            req_in   = request_bytes;
            ptr_in   = block_offset;
            res_in   = '0;
            moved_in = 1'b0;
            copy_in  = '0;
         end
         OP_WALK_START: begin
            cur_in = '0;
            rd_en  = 1'b1;
            rd_off = '0;
         end
         OP_WALK: begin
            if (status.fit) begin
               if (status.split) begin
                  // Carve a free remainder block behind the allocated part.
                  wr_en   = 1'b1;
                  wr_off  = split_off;
                  wr_word = {1'b1, remain[LW-1:0]};
               end else begin
                  wr_en   = 1'b1;
                  wr_off  = cur_ff;
                  wr_word = {1'b0, rd_len};
                  res_in  = cur_usable[OFF_W-1:0];
               end
            end else if (!status.walk_end) begin
               cur_in = walk_next;
               rd_en  = 1'b1;
               rd_off = walk_next;
            end
         end
         OP_SPLIT: begin
            wr_en   = 1'b1;
            wr_off  = cur_ff;
            wr_word = {1'b0, need[LW-1:0]};
            res_in  = cur_usable[OFF_W-1:0];
         end
         OP_RD_HDR: begin
            rd_en  = 1'b1;
            rd_off = hdr_off;
         end
         OP_RSZ_CHK: begin
            old_len_in = rd_len;
            if (status.in_place) begin
               res_in = ptr_ff;
            end
         end
         OP_REL_MARK: begin
            wr_en   = 1'b1;
            wr_off  = hdr_off;
            wr_word = {1'b1, rd_len};
            len_in  = rd_len;
            if (!status.mark_end) begin
               rd_en  = 1'b1;
               rd_off = mark_next;
            end
         end
         OP_REL_MERGE: begin
            // Absorb the following free block into the released one.
            if (rd_free) begin
               wr_en   = 1'b1;
               wr_off  = hdr_off;
               wr_word = {1'b1, merged[LW-1:0]};
               len_in  = merged[LW-1:0];
               if (!status.merge_end) begin
                  rd_en  = 1'b1;
                  rd_off = merge_next;
               end
            end
         end
         default: begin
         end
      endcase

      if (cmd.set_moved) begin
         moved_in = 1'b1;
         copy_in  = old_len_w[COPY_W-1:0];
      end

      if (cmd.publish) begin
         out_res_in   = res_ff;
         out_moved_in = moved_ff;
         out_copy_in  = copy_ff;
      end
   end

   // Header memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en && (wr_off < POOL_C)) begin
         mem_ff[wr_off[SW+1:2]] <= wr_word;
      end
      if (rd_en) begin
         rd_word_ff <= mem_ff[rd_off[SW+1:2]];
         rd_oob_ff  <= (rd_off >= POOL_C);
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      act_ff       <= act_in;
      req_ff       <= req_in;
      ptr_ff       <= ptr_in;
      cur_ff       <= cur_in;
      len_ff       <= len_in;
      old_len_ff   <= old_len_in;
      res_ff       <= res_in;
      moved_ff     <= moved_in;
      copy_ff      <= copy_in;
      out_res_ff   <= out_res_in;
      out_moved_ff <= out_moved_in;
      out_copy_ff  <= out_copy_in;
   end

   assign result_offset = out_res_ff;
   assign success       = (out_res_ff != '0);
   assign moved         = out_moved_ff;
   assign copy_bytes    = out_copy_ff;

endmodule

// File: design/ffpa_ctrl.sv
// ============================================================================
// First-fit pool allocator controller
// Sequences allocate, release and resize over the datapath and owns the
// input and result handshakes.
// ============================================================================
module ffpa_ctrl
   import ffpa_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   output logic            rsp_tvalid,
   input  logic            rsp_tready,
   input  ffpa_status_type status,
   output ffpa_cmd_type    cmd
);

   typedef enum logic [11:0] {
      ST_INIT      = 12'b0000_0000_0001,
      ST_IDLE      = 12'b0000_0000_0010,
      ST_DECODE    = 12'b0000_0000_0100,
      ST_ALLOC     = 12'b0000_0000_1000,
      ST_WALK      = 12'b0000_0001_0000,
      ST_SPLIT     = 12'b0000_0010_0000,
      ST_RSZ_RD    = 12'b0000_0100_0000,
      ST_RSZ_CHK   = 12'b0000_1000_0000,
      ST_REL_RD    = 12'b0001_0000_0000,
      ST_REL_MARK  = 12'b0010_0000_0000,
      ST_REL_MERGE = 12'b0100_0000_0000,
      ST_DONE      = 12'b1000_0000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      relocate_ff, relocate_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // Next state and command decode.
   always_comb begin
      state_in      = state_ff;
      relocate_in   = relocate_ff;
      cmd.op        = OP_IDLE;
      cmd.set_moved = 1'b0;
      cmd.publish   = 1'b0;
      req_tready    = 1'b0;

      case (state_ff)
         ST_INIT: begin
            cmd.op   = OP_INIT;
            state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.op      = OP_LOAD;
               relocate_in = 1'b0;
               state_in    = ST_DECODE;
            end
         end
         ST_DECODE: begin
            state_in = ST_DONE;
            case (status.act)
               ACT_ALLOC: begin
                  if (!status.req_zero) begin
                     state_in = ST_ALLOC;
                  end
               end
               ACT_RELEASE: begin
                  if (!status.ptr_zero && status.ptr_ok) begin
                     state_in = ST_REL_RD;
                  end
               end
               ACT_RESIZE: begin
                  if (status.ptr_zero) begin
                     if (!status.req_zero) begin
                        state_in = ST_ALLOC;
                     end
                  end else if (status.ptr_ok) begin
                     state_in = status.req_zero ? ST_REL_RD : ST_RSZ_RD;
                  end
               end
               default: begin
               end
            endcase
         end
         ST_ALLOC: begin
            cmd.op   = OP_WALK_START;
            state_in = ST_WALK;
         end
         ST_WALK: begin
            // One block of the chain per cycle.
            cmd.op = OP_WALK;
            if (status.fit) begin
               if (status.split) begin
                  state_in = ST_SPLIT;
               end else if (relocate_ff) begin
                  cmd.set_moved = 1'b1;
                  state_in      = ST_REL_RD;
               end else begin
                  state_in = ST_DONE;
               end
            end else if (status.walk_end) begin
               state_in = ST_DONE;
            end
         end
         ST_SPLIT: begin
            cmd.op = OP_SPLIT;
            if (relocate_ff) begin
               cmd.set_moved = 1'b1;
               state_in      = ST_REL_RD;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_RSZ_RD: begin
            cmd.op   = OP_RD_HDR;
            state_in = ST_RSZ_CHK;
         end
         ST_RSZ_CHK: begin
            cmd.op = OP_RSZ_CHK;
            if (status.in_place) begin
               state_in = ST_DONE;
            end else begin
               relocate_in = 1'b1;
               state_in    = ST_ALLOC;
            end
         end
         ST_REL_RD: begin
            cmd.op   = OP_RD_HDR;
            state_in = ST_REL_MARK;
         end
         ST_REL_MARK: begin
            cmd.op   = OP_REL_MARK;
            state_in = status.mark_end ? ST_DONE : ST_REL_MERGE;
         end
         ST_REL_MERGE: begin
            cmd.op = OP_REL_MERGE;
            if (status.merge_end) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // Hand the result over once the output register is free.
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.publish = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   // Output register valid flag.
   always_comb begin
      if (cmd.publish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         relocate_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         relocate_ff  <= relocate_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

// File: design/first_fit_pool_allocator.sv
// ============================================================================
// First-fit pool allocator
// Allocate, release and resize over a byte pool kept as a chain of headers.
// ============================================================================
// One request beat yields one response beat. The pool starts after reset as
// a single free block; the state after reset writes its header, and no
// request is taken while it does so. Allocate decodes the beat, starts the
// walk and then reads the headers of the blocks on the chain one at a time,
// since the header memory has one read port and each block's header is read
// once; a split adds a step. Release reads the block's header, marks it free
// and absorbs the free blocks behind it one at a time. Resize in place reads
// the header and checks the size; otherwise it runs the allocate walk and,
// when the block moves, the release of the old block. A request beat is
// taken only between items, but a finished response may wait in its output
// register while the next request is already being worked on. Offset 0
// means null on both sides.
module first_fit_pool_allocator
   import ffpa_pkg::*;
#(
   parameter int HEADER_BYTES = 12
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // action [1:0], request_bytes [17:2], block_offset [28:18], zero [31:29]
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // result_offset [10:0], success [11], moved [12], copy_bytes [23:13]
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   ffpa_cmd_type      cmd;
   ffpa_status_type   status;
   logic [OFF_W-1:0]  result_offset;
   logic              success;
   logic              moved;
   logic [COPY_W-1:0] copy_bytes;

   ffpa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   ffpa_datapath #(
      .HEADER_BYTES (HEADER_BYTES)
   ) u_datapath (
      .clock         (clock),
      .action        (req_tdata[1:0]),
      .request_bytes (req_tdata[17:2]),
      .block_offset  (req_tdata[28:18]),
      .cmd           (cmd),
      .status        (status),
      .result_offset (result_offset),
      .success       (success),
      .moved         (moved),
      .copy_bytes    (copy_bytes)
   );

   // Response beat packing.
   assign rsp_tdata = {copy_bytes, moved, success, result_offset};

endmodule

// File: verif/first_fit_pool_allocator_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// First-fit pool allocator testbench
// Drives allocate, release and resize beats into the allocator and checks
// every response beat against a cycle-free model of the header chain. A
// short directed plan covers the pool extremes, null and bad pointers, zero
// and oversize requests and the unknown action. A long random run of
// allocation traffic with random stalls on both sides follows.
// ============================================================================
module first_fit_pool_allocator_tb;
   import ffpa_pkg::*;

   localparam int POOL      = POOL_SIZE;
   localparam int HDR       = 12;
   localparam int SLOTS     = POOL / 4;
   localparam int ITEMS     = 1600;
   localparam int DRAIN     = 300;
   localparam int LIMIT     = 2000000;
   localparam int PAUSE_AT  = 800;

   // Request beat, last field in the lowest bits.
   typedef struct packed {
      logic [2:0]       pad;
      logic [OFF_W-1:0] block_offset;
      logic [REQ_W-1:0] request_bytes;
      action_type       action;
   } req_beat_type;

   // Response beat, last field in the lowest bits.
   typedef struct packed {
      logic [COPY_W-1:0] copy_bytes;
      logic              moved;
      logic              success;
      logic [OFF_W-1:0]  result_offset;
   } rsp_beat_type;

   typedef struct {
      action_type   act;
      int unsigned  req;
      int unsigned  ptr;
      bit           typed;
      rsp_beat_type rsp;
   } plan_row_type;

   logic                   clock;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   // Shadow copy of the header store.
   logic [11:0]  hdr_len  [SLOTS];
   logic         hdr_free [SLOTS];

   rsp_beat_type pending_rsp[$];
   plan_row_type directed_plan[$];
   int unsigned  busy_areas[$];
   int unsigned  vacant_areas[$];
   int           mismatches = 0;
   int unsigned  cycles     = 0;
   bit           steady     = 1'b0;

   first_fit_pool_allocator #(
      .HEADER_BYTES (HDR)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Header reads beyond the pool give length 0 and not free.
   function automatic int unsigned len_of(int unsigned off);
      return (off >= POOL) ? 0 : int'(hdr_len[off >> 2]);
   endfunction

   function automatic bit free_of(int unsigned off);
      return (off >= POOL) ? 1'b0 : hdr_free[off >> 2];
   endfunction

   // Header writes beyond the pool are dropped; lengths saturate at the pool size.
   function automatic void store_len(int unsigned off, int unsigned len);
      if (off < POOL) begin
         hdr_len[off >> 2] = 12'((len > POOL) ? POOL : len);
      end
   endfunction

   function automatic void store_free(int unsigned off, bit mark);
      if (off < POOL) begin
         hdr_free[off >> 2] = mark;
      end
   endfunction

   // Walk from the pool start to the first free block that fits, splitting it
   // when the remainder can carry a header and one granule.
   function automatic int unsigned first_fit(int unsigned req);
      int unsigned need;
      int unsigned off;
      int unsigned len;
      int unsigned res;
      bit          found;
      need  = (req + 7) & 32'hFFFF_FFF8;
      off   = 0;
      res   = 0;
      found = 1'b0;
      if (req == 0) begin
         return 0;
      end
      while (off < POOL && !found) begin
         len = len_of(off);
         if (free_of(off) && len >= need) begin
            if (len >= need + HDR + 8) begin
               store_len(off + HDR + need, len - need - HDR);
               store_free(off + HDR + need, 1'b1);
               store_len(off, need);
            end
            store_free(off, 1'b0);
            res   = off + HDR;
            found = 1'b1;
         end else begin
            off += HDR + len;
         end
      end
      return res;
   endfunction

   // Mark a block free and absorb the free blocks that follow it.
   function automatic void free_and_merge(int unsigned hdr);
      int unsigned len;
      int unsigned nx;
      bit          done;
      done = 1'b0;
      store_free(hdr, 1'b1);
      while (!done) begin
         len = len_of(hdr);
         nx  = hdr + HDR + len;
         if (nx >= POOL || !free_of(nx)) begin
            done = 1'b1;
         end else begin
            store_len(hdr, len + HDR + len_of(nx));
            if (len_of(hdr) == len) begin
               done = 1'b1;
            end
         end
      end
   endfunction

   // Apply one request to the shadow store and return the response it earns.
   function automatic rsp_beat_type serve_request(action_type act, int unsigned req,
                                                  int unsigned ptr);
      rsp_beat_type r;
      int unsigned  res;
      int unsigned  old_len;
      int unsigned  cp;
      logic         mv;
      res = 0;
      cp  = 0;
      mv  = 1'b0;
      case (act)
         ACT_ALLOC: begin
            res = first_fit(req);
         end
         ACT_RELEASE: begin
            if (ptr >= HDR && ptr < POOL) begin
               free_and_merge(ptr - HDR);
            end
         end
         ACT_RESIZE: begin
            if (ptr == 0) begin
               res = first_fit(req);
            end else if (ptr >= HDR && ptr < POOL) begin
               old_len = len_of(ptr - HDR);
               if (req == 0) begin
                  free_and_merge(ptr - HDR);
               end else if (old_len >= req) begin
                  res = ptr;
               end else begin
                  res = first_fit(req);
                  if (res != 0) begin
                     mv = 1'b1;
                     cp = (old_len < req) ? old_len : req;
                     free_and_merge(ptr - HDR);
                  end
               end
            end
         end
         default: begin
         end
      endcase
      r.result_offset = OFF_W'(res);
      r.success       = (res != 0);
      r.moved         = mv;
      r.copy_bytes    = COPY_W'(cp);
      return r;
   endfunction

   // Sort the chain into allocated and free areas for pointer selection.
   function automatic void scan_chain();
      int unsigned off;
      off = 0;
      busy_areas.delete();
      vacant_areas.delete();
      while (off < POOL) begin
         if (free_of(off)) begin
            vacant_areas.push_back(off + HDR);
         end else begin
            busy_areas.push_back(off + HDR);
         end
         off += HDR + len_of(off);
      end
   endfunction

   task automatic add_row(action_type act, int unsigned req, int unsigned ptr, bit typed,
                          int unsigned res);
      plan_row_type row;
      row.act                = act;
      row.req                = req;
      row.ptr                = ptr;
      row.typed              = typed;
      row.rsp.result_offset  = OFF_W'(res);
      row.rsp.success        = (res != 0);
      row.rsp.moved          = 1'b0;
      row.rsp.copy_bytes     = '0;
      directed_plan.push_back(row);
   endtask

   // Present one request beat from a falling edge, idling at random first, and
   // record its expected response once the beat is taken.
   task automatic send_beat(req_beat_type b, bit typed, rsp_beat_type typed_rsp);
      rsp_beat_type model_rsp;
      while (!steady && $urandom_range(0, 99) < 30) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      model_rsp = serve_request(b.action, b.request_bytes, b.block_offset);
      pending_rsp.push_back(typed ? typed_rsp : model_rsp);
      scan_chain();
      @(negedge clock);
   endtask

   // Stimulus: directed plan, then random allocation traffic.
   initial begin
      req_beat_type b;
      int           counted;
      int           roll;
      int           sub;
      int           rel_share;
      int unsigned  p;
      int unsigned  cur;
      bit           counts;
      bit           paused;
      counted = 0;
      paused  = 1'b0;
      foreach (hdr_len[i]) begin
         hdr_len[i]  = '0;
         hdr_free[i] = 1'b0;
      end
      hdr_len[0]  = 12'(POOL - HDR);
      hdr_free[0] = 1'b1;
      scan_chain();

      // Extremes, null and bad pointers, unknown action, then a worked chain.
      add_row(ACT_ALLOC,   2032,  0,    1, 12);
      add_row(ACT_ALLOC,   1,     0,    1, 0);
      add_row(ACT_RELEASE, 65535, 12,   1, 0);
      add_row(ACT_ALLOC,   0,     2047, 1, 0);
      add_row(ACT_ALLOC,   65535, 2047, 1, 0);
      add_row(ACT_NONE,    65535, 2047, 1, 0);
      add_row(ACT_RELEASE, 0,     0,    1, 0);
      add_row(ACT_RELEASE, 0,     1,    1, 0);
      add_row(ACT_RESIZE,  8,     11,   1, 0);
      add_row(ACT_RESIZE,  1,     0,    1, 12);
      add_row(ACT_ALLOC,   100,   0,    0, 0);
      add_row(ACT_RESIZE,  8,     12,   1, 12);
      add_row(ACT_RESIZE,  200,   12,   0, 0);
      add_row(ACT_RESIZE,  0,     32,   1, 0);
      add_row(ACT_RELEASE, 0,     148,  0, 0);
      add_row(ACT_ALLOC,   8,     0,    0, 0);
      add_row(ACT_ALLOC,   2000,  0,    0, 0);
      add_row(ACT_ALLOC,   1900,  0,    0, 0);
      add_row(ACT_RESIZE,  1900,  148,  0, 0);
      add_row(ACT_RESIZE,  1901,  148,  0, 0);
      add_row(ACT_ALLOC,   104,   0,    0, 0);
      add_row(ACT_RELEASE, 0,     12,   0, 0);
      add_row(ACT_RELEASE, 0,     32,   0, 0);
      add_row(ACT_RELEASE, 0,     148,  0, 0);
      add_row(ACT_ALLOC,   2036,  0,    0, 0);

      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_plan[i]) begin
         b.pad           = '0;
         b.action        = directed_plan[i].act;
         b.request_bytes = REQ_W'(directed_plan[i].req);
         b.block_offset  = OFF_W'(directed_plan[i].ptr);
         send_beat(b, directed_plan[i].typed, directed_plan[i].rsp);
      end

      while (counted < ITEMS) begin
         // Once, hold the sender until the allocator has answered everything.
         if (counted >= PAUSE_AT && !paused) begin
            paused = 1'b1;
            req_tvalid <= 1'b0;
            do begin
               @(negedge clock);
            end while (pending_rsp.size() != 0);
         end
         steady <= (counted >= 300 && counted < 500);

         roll            = $urandom_range(0, 99);
         rel_share       = (busy_areas.size() > 16) ? 45 : 20;
         counts          = 1'b1;
         b.pad           = '0;
         b.request_bytes = REQ_W'($urandom);
         b.block_offset  = OFF_W'($urandom);
         if (roll < 6) begin
            // Noise: ignored beats and operations on blocks already free.
            sub = $urandom_range(0, 4);
            case (sub)
               0: begin
                  b.action = ACT_NONE;
                  counts   = 1'b0;
               end
               1: begin
                  b.action       = ACT_RELEASE;
                  b.block_offset = '0;
                  counts         = 1'b0;
               end
               2: begin
                  b.action       = ACT_RELEASE;
                  b.block_offset = OFF_W'($urandom_range(1, HDR - 1));
                  counts         = 1'b0;
               end
               3: begin
                  b.action       = ACT_RESIZE;
                  b.block_offset = OFF_W'($urandom_range(1, HDR - 1));
                  counts         = 1'b0;
               end
               default: begin
                  if (vacant_areas.size() == 0) begin
                     b.action = ACT_NONE;
                     counts   = 1'b0;
                  end else begin
                     b.action        = ($urandom_range(0, 1) != 0) ? ACT_RELEASE
                                                                   : ACT_RESIZE;
                     b.block_offset  = OFF_W'(vacant_areas[$urandom_range(0,
                                              vacant_areas.size() - 1)]);
                     b.request_bytes = REQ_W'($urandom_range(0, 300));
                  end
               end
            endcase
         end else if (roll < 6 + rel_share && busy_areas.size() != 0) begin
            b.action       = ACT_RELEASE;
            b.block_offset = OFF_W'(busy_areas[$urandom_range(0, busy_areas.size() - 1)]);
         end else if (roll < 24 + rel_share && busy_areas.size() != 0) begin
            // Resize a live block: shrink or keep, grow, or drop it.
            p   = busy_areas[$urandom_range(0, busy_areas.size() - 1)];
            cur = len_of(p - HDR);
            sub = $urandom_range(0, 9);
            b.action       = ACT_RESIZE;
            b.block_offset = OFF_W'(p);
            if (sub < 3) begin
               b.request_bytes = REQ_W'($urandom_range(1, cur));
            end else if (sub < 9) begin
               b.request_bytes = REQ_W'($urandom_range(cur + 1, cur + 160));
            end else begin
               b.request_bytes = '0;
            end
         end else begin
            // Allocation, mostly small, sometimes through a null-pointer resize.
            sub = $urandom_range(0, 99);
            if (sub < 70) begin
               b.request_bytes = REQ_W'($urandom_range(1, 64));
            end else if (sub < 88) begin
               b.request_bytes = REQ_W'($urandom_range(65, 400));
            end else if (sub < 92) begin
               b.request_bytes = '0;
            end else if (sub < 96) begin
               b.request_bytes = REQ_W'($urandom_range(401, POOL - HDR));
            end else begin
               b.request_bytes = REQ_W'($urandom_range(POOL - HDR + 1, 65535));
            end
            if ($urandom_range(0, 9) == 0) begin
               b.action       = ACT_RESIZE;
               b.block_offset = '0;
            end else begin
               b.action = ACT_ALLOC;
            end
         end
         send_beat(b, 1'b0, '0);
         if (counts) begin
            counted++;
         end
      end

      // Let the last responses drain, then give the verdict.
      req_tvalid <= 1'b0;
      while (pending_rsp.size() != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN) @(negedge clock);
      if (mismatches == 0 && pending_rsp.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // Response side stalls at random except during the steady stretch.
   always @(negedge clock) begin
      rsp_tready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 30);
   end

   // Compare each response beat with the oldest expectation.
   always @(posedge clock) begin
      rsp_beat_type got;
      rsp_beat_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (pending_rsp.size() == 0) begin
            $error("unexpected response beat %h", rsp_tdata);
            mismatches++;
         end else begin
            want = pending_rsp.pop_front();
            if (got.result_offset !== want.result_offset) begin
               $error("result_offset: expected %0d, actual %0d",
                      want.result_offset, got.result_offset);
               mismatches++;
            end
            if (got.success !== want.success) begin
               $error("success: expected %0d, actual %0d", want.success, got.success);
               mismatches++;
            end
            if (got.moved !== want.moved) begin
               $error("moved: expected %0d, actual %0d", want.moved, got.moved);
               mismatches++;
            end
            if (got.copy_bytes !== want.copy_bytes) begin
               $error("copy_bytes: expected %0d, actual %0d",
                      want.copy_bytes, got.copy_bytes);
               mismatches++;
            end
         end
      end
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

endmodule

// File: first_fit_pool_allocator.f
design/ffpa_pkg.sv
design/ffpa_datapath.sv
design/ffpa_ctrl.sv
design/first_fit_pool_allocator.sv
verif/first_fit_pool_allocator_tb.sv
